// ===== hw/rtl/tlb_lookup_clock_replace_defines.svh =====
// assertion macros for the tlb lookup block
// no dependencies; included by the top level only
`ifndef TLB_LOOKUP_CLOCK_REPLACE_DEFINES_SVH
`define TLB_LOOKUP_CLOCK_REPLACE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TLB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define TLB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tlb_lcr_pkg.sv =====
// shared types and constants for the tlb lookup block
// used by tlb_lcr_cell and tlb_lookup_clock_replace
package tlb_lcr_pkg;

    localparam int PAGE_BITS      = 20;
    localparam int FRAME_BITS     = 20;
    localparam int SLOT_OUT_BITS  = 4;
    localparam int COUNT_BITS     = 32;
    localparam int CFG_BITS       = 5;
    localparam int TLB_DEPTH_DEF  = 16;
    localparam int TLB_DEPTH_MAX  = 64;
    localparam int SLOT_W         = $clog2(TLB_DEPTH_MAX);
    localparam int CNT_W          = $clog2(TLB_DEPTH_MAX + 1);
    localparam logic [CFG_BITS-1:0] ACTIVE_RESET = CFG_BITS'(16);

    typedef struct packed {
        logic [PAGE_BITS-1:0]  page_number;
        logic                  write_access;
        logic [FRAME_BITS-1:0] walk_frame;
    } req_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0]    frame_number;
        logic                     hit;
        logic [SLOT_OUT_BITS-1:0] slot;
        logic [COUNT_BITS-1:0]    hit_count;
    } rsp_t;

    // request token and search results passed from cell to cell
    typedef struct packed {
        logic                  tok;
        logic [PAGE_BITS-1:0]  page;
        logic                  wr;
        logic [FRAME_BITS-1:0] walk;
        logic                  found;
        logic [SLOT_W-1:0]     hit_slot;
        logic [FRAME_BITS-1:0] hit_frame;
        logic                  have_inv;
        logic [SLOT_W-1:0]     inv_slot;
        logic                  have_unused;
        logic [SLOT_W-1:0]     unused_slot;
    } carry_t;

    // state update broadcast to every cell at the end of a request
    typedef struct packed {
        logic                  en;
        logic                  hit;
        logic                  sweep;
        logic [SLOT_W-1:0]     slot;
        logic [CNT_W-1:0]      sweep_lim;
        logic [PAGE_BITS-1:0]  page;
        logic [FRAME_BITS-1:0] frame;
        logic                  wr;
    } upd_t;

endpackage

// ===== hw/rtl/tlb_lcr_cell.sv =====
// one tlb entry plus its stage of the search chain
// depends on tlb_lcr_pkg
module tlb_lcr_cell #(
    parameter int IDX = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [tlb_lcr_pkg::CNT_W-1:0] n_active,
    input  tlb_lcr_pkg::carry_t       carry_in,
    output tlb_lcr_pkg::carry_t       carry_out,
    input  tlb_lcr_pkg::upd_t         upd
);

    logic [tlb_lcr_pkg::PAGE_BITS-1:0]  page_reg;
    logic [tlb_lcr_pkg::FRAME_BITS-1:0] frame_reg;
    logic                               valid_reg;
    logic                               used_reg;
    logic                               dirty_reg;
    tlb_lcr_pkg::carry_t                carry_reg;
    tlb_lcr_pkg::carry_t                carry_next;
    logic                               act;
    logic                               match;
    logic                               mine;

    assign act   = tlb_lcr_pkg::CNT_W'(IDX) < n_active;
    assign match = act && valid_reg && (page_reg == carry_in.page);
    assign mine  = upd.slot == tlb_lcr_pkg::SLOT_W'(IDX);

    always_comb
    begin
        carry_next = carry_in;
        if (!carry_in.found && match)
        begin
            carry_next.found     = 1'b1;
            carry_next.hit_slot  = tlb_lcr_pkg::SLOT_W'(IDX);
            carry_next.hit_frame = frame_reg;
        end
        if (!carry_in.have_inv && act && !valid_reg)
        begin
            carry_next.have_inv = 1'b1;
            carry_next.inv_slot = tlb_lcr_pkg::SLOT_W'(IDX);
        end
        if (!carry_in.have_unused && act && !used_reg)
        begin
            carry_next.have_unused = 1'b1;
            carry_next.unused_slot = tlb_lcr_pkg::SLOT_W'(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
            valid_reg <= 1'b0;
            used_reg  <= 1'b0;
            dirty_reg <= 1'b0;
        end
        else
        begin
            carry_reg <= carry_next;
            if (upd.en)
            begin
                if (upd.hit)
                begin
                    if (mine)
                    begin
                        used_reg  <= 1'b1;
                        dirty_reg <= dirty_reg | upd.wr;
                    end
                end
                else if (mine)
                begin
                    valid_reg <= 1'b1;
                    used_reg  <= 1'b1;
                    dirty_reg <= upd.wr;
                end
                else if (upd.sweep && (tlb_lcr_pkg::CNT_W'(IDX) < upd.sweep_lim))
                begin
                    // clock hand passed this entry
                    used_reg <= 1'b0;
                end
            end
        end
    end

    // entry payload, written on fill only
    always_ff @(posedge clk)
    begin
        if (upd.en && !upd.hit && mine)
        begin
            page_reg  <= upd.page;
            frame_reg <= upd.frame;
        end
    end

    assign carry_out = carry_reg;

endmodule

// ===== hw/rtl/tlb_lookup_clock_replace.sv =====
// a request walks the row of entry cells one cell per cycle, registered in each,
// before the state update and the registered result strobe; busy holds until it
//   leaves the last cell, so a new request is taken only once the previous one is done
// reset: all entries invalid, used and dirty clear, hit total zero, active 16
// the receiver cannot stall: each result is shown for one cycle on done
module tlb_lookup_clock_replace #(
    parameter int TLB_DEPTH = tlb_lcr_pkg::TLB_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  tlb_lcr_pkg::req_t                req,
    output logic                             done,
    output tlb_lcr_pkg::rsp_t                rsp,
    input  logic                             cfg_we,
    input  logic [tlb_lcr_pkg::CFG_BITS-1:0] cfg_data
);

    // active entry count register
    logic [tlb_lcr_pkg::CFG_BITS-1:0] active_reg;
    logic [tlb_lcr_pkg::CNT_W-1:0]    active_ext;
    logic [tlb_lcr_pkg::CNT_W-1:0]    n_active;

    // request control and result registers
    logic                               busy_reg;
    logic                               done_reg;
    tlb_lcr_pkg::rsp_t                  rsp_reg;
    logic [tlb_lcr_pkg::COUNT_BITS-1:0] hit_total_reg;
    logic [tlb_lcr_pkg::COUNT_BITS-1:0] hit_total_next;
    logic                               accept;

    // search chain
    tlb_lcr_pkg::carry_t head;
    tlb_lcr_pkg::carry_t chain [TLB_DEPTH+1];
    logic [TLB_DEPTH-1:0] tok_vec;
    tlb_lcr_pkg::carry_t last;
    tlb_lcr_pkg::upd_t   upd;
    logic [tlb_lcr_pkg::SLOT_W-1:0] slot_sel;

    assign accept = start && !busy_reg;

    // clamp the active count to 1..TLB_DEPTH
    assign active_ext = tlb_lcr_pkg::CNT_W'(active_reg);
    always_comb
    begin
        if (active_ext == '0)
            n_active = tlb_lcr_pkg::CNT_W'(1);
        else if (active_ext > tlb_lcr_pkg::CNT_W'(TLB_DEPTH))
            n_active = tlb_lcr_pkg::CNT_W'(TLB_DEPTH);
        else
            n_active = active_ext;
    end

    // the request enters the chain at cell 0 with nothing found yet
    always_comb
    begin
        head      = '0;
        head.tok  = accept;
        head.page = req.page_number;
        head.wr   = req.write_access;
        head.walk = req.walk_frame;
    end

    assign chain[0] = head;

    genvar gi;
    generate
        for (gi = 0; gi < TLB_DEPTH; gi++)
        begin : g_cell
            tlb_lcr_cell #(
                .IDX (gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .n_active  (n_active),
                .carry_in  (chain[gi]),
                .carry_out (chain[gi+1]),
                .upd       (upd)
            );
            assign tok_vec[gi] = chain[gi+1].tok;
        end
    endgenerate

    assign last = chain[TLB_DEPTH];

    // replacement choice once the token leaves the last cell:
    // hit slot, else first invalid entry, else first unused entry, else entry 0
    always_comb
    begin
        if (last.found)
            slot_sel = last.hit_slot;
        else if (last.have_inv)
            slot_sel = last.inv_slot;
        else if (last.have_unused)
            slot_sel = last.unused_slot;
        else
            slot_sel = '0;
    end

    always_comb
    begin
        upd       = '0;
        upd.en    = last.tok;
        upd.hit   = last.found;
        upd.slot  = slot_sel;
        upd.page  = last.page;
        upd.frame = last.walk;
        upd.wr    = last.wr;
        // sweep only when every active entry is valid; the hand stops at the
        // first unused entry, or clears the whole active range
        upd.sweep = !last.found && !last.have_inv;
        if (last.have_unused)
            upd.sweep_lim = tlb_lcr_pkg::CNT_W'(last.unused_slot);
        else
            upd.sweep_lim = n_active;
    end

    assign hit_total_next = hit_total_reg + tlb_lcr_pkg::COUNT_BITS'(last.found);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= tlb_lcr_pkg::ACTIVE_RESET;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            hit_total_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                active_reg <= cfg_data;
            done_reg <= last.tok;
            if (accept)
                busy_reg <= 1'b1;
            else if (last.tok)
                busy_reg <= 1'b0;
            if (last.tok)
                hit_total_reg <= hit_total_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (last.tok)
        begin
            rsp_reg.frame_number <= last.found ? last.hit_frame : last.walk;
            rsp_reg.hit          <= last.found;
            rsp_reg.slot         <= tlb_lcr_pkg::SLOT_OUT_BITS'(slot_sel);
            rsp_reg.hit_count    <= hit_total_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    `include "tlb_lookup_clock_replace_defines.svh"

    // one request in flight at most
    `TLB_ASSERT_NOW(a_one_token, clk, rst_n, 1'b1, $onehot0(tok_vec), "two requests in chain")
    // a request in the chain always holds busy
    `TLB_ASSERT_NOW(a_tok_busy, clk, rst_n, (tok_vec != '0), busy_reg, "request while idle")
    // result comes with busy released
    `TLB_ASSERT_NOW(a_done_idle, clk, rst_n, done_reg, !busy_reg, "result while still busy")
    // reported hit count matches the running total
    `TLB_ASSERT_NOW(a_count, clk, rst_n, done_reg, rsp_reg.hit_count == hit_total_reg, "hit count")
    // accept starts the walk through the chain
    `TLB_ASSERT_NEXT(a_accept, clk, rst_n, accept, busy_reg && chain[1].tok, "request lost")

endmodule

// ===== bench/tlb_translation_checker.sv =====
`timescale 1ns / 100ps
// translation checker for the tlb lookup block: watches requests, config writes and results
// keeps its own copy of the entry table; depends on tlb_lcr_pkg for req_t and rsp_t
module tlb_translation_checker
    import tlb_lcr_pkg::*;
#(
    parameter int TLB_DEPTH = TLB_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  req_t                req,
    input  logic                done,
    input  rsp_t                rsp,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_data,
    output int                  mismatch_count,
    output int                  translations_pending
);

    logic [PAGE_BITS-1:0]  page_tag  [TLB_DEPTH];
    logic [FRAME_BITS-1:0] frame_tag [TLB_DEPTH];
    logic                  valid_bit [TLB_DEPTH];
    logic                  used_bit  [TLB_DEPTH];
    logic                  dirty_bit [TLB_DEPTH];
    logic [COUNT_BITS-1:0] hits_seen;
    logic [CFG_BITS-1:0]   active_setting;

    rsp_t translations_due [$];

    initial mismatch_count = 0;

    function automatic rsp_t predict_translation(req_t r);
        int   n;
        int   idx;
        rsp_t p;
        n = (active_setting < 1) ? 1 : ((active_setting > TLB_DEPTH) ? TLB_DEPTH : active_setting);
        idx = -1;
        for (int i = 0; i < n; i++)
            if (idx < 0 && valid_bit[i] && page_tag[i] == r.page_number)
                idx = i;
        p.hit = (idx >= 0);
        if (p.hit)
        begin
            hits_seen = hits_seen + 1'b1;
            used_bit[idx] = 1'b1;
            dirty_bit[idx] = dirty_bit[idx] | r.write_access;
            p.frame_number = frame_tag[idx];
        end
        else
        begin
            // first invalid entry, else clock sweep from entry 0
            for (int i = 0; i < n; i++)
                if (idx < 0 && !valid_bit[i])
                    idx = i;
            for (int i = 0; i < n && idx < 0; i++)
            begin
                if (!used_bit[i])
                    idx = i;
                else
                    used_bit[i] = 1'b0;
            end
            if (idx < 0)
                idx = 0;
            page_tag[idx] = r.page_number;
            frame_tag[idx] = r.walk_frame;
            valid_bit[idx] = 1'b1;
            used_bit[idx] = 1'b1;
            dirty_bit[idx] = r.write_access;
            p.frame_number = r.walk_frame;
        end
        p.slot = idx[SLOT_OUT_BITS-1:0];
        p.hit_count = hits_seen;
        return p;
    endfunction

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %h got %h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TLB_DEPTH; i++)
            begin
                valid_bit[i] = 1'b0;
                used_bit[i] = 1'b0;
                dirty_bit[i] = 1'b0;
            end
            hits_seen = '0;
            active_setting = ACTIVE_RESET;
            translations_due.delete();
        end
        else
        begin
            // a result can land on the same edge as the next request
            if (done)
            begin
                if (translations_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with nothing outstanding, expected none got %h",
                             $time, rsp);
                end
                else
                begin
                    want = translations_due.pop_front();
                    report_field("frame_number", 32'(want.frame_number), 32'(rsp.frame_number));
                    report_field("hit", 32'(want.hit), 32'(rsp.hit));
                    report_field("slot", 32'(want.slot), 32'(rsp.slot));
                    report_field("hit_count", want.hit_count, rsp.hit_count);
                end
            end
            if (cfg_we)
                active_setting = cfg_data;
            if (start && !busy)
                translations_due.push_back(predict_translation(req));
        end
        translations_pending = translations_due.size();
    end

endmodule

// ===== bench/tlb_lookup_clock_replace_tb.sv =====
`timescale 1ns / 100ps
// top of the tlb lookup bench: clock, reset, request stimulus, config writes and verdict
// needs tlb_lcr_pkg, tlb_lookup_clock_replace and tlb_translation_checker
module tlb_lookup_clock_replace_tb;
    import tlb_lcr_pkg::*;

    // no request or result for this many cycles means the block is stuck
    localparam int STALL_LIMIT = 2000;
    // requests per random phase, ten phases in all
    localparam int PHASE_REQUESTS = 135;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    req_t                req;
    logic                done;
    rsp_t                rsp;
    logic                cfg_we;
    logic [CFG_BITS-1:0] cfg_data;

    int mismatch_count;
    int translations_pending;
    int quiet_cycles;
    bit gaps_on;

    tlb_lookup_clock_replace DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    tlb_translation_checker #(
        .TLB_DEPTH (TLB_DEPTH_DEF)
    ) checker_i (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .req                  (req),
        .done                 (done),
        .rsp                  (rsp),
        .cfg_we               (cfg_we),
        .cfg_data             (cfg_data),
        .mismatch_count       (mismatch_count),
        .translations_pending (translations_pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog: any accepted request or result restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // one request; start stays high after acceptance so back-to-back requests
    // never drop and raise it within the same step
    task automatic issue_access(input logic [PAGE_BITS-1:0] pg, input logic wr,
                                input logic [FRAME_BITS-1:0] wf);
        req_t r;
        r.page_number = pg;
        r.write_access = wr;
        r.walk_frame = wf;
        @(negedge clk);
        // random sender idling in the cycles where the block could take a request
        if (gaps_on)
            while (busy || $urandom_range(0, 99) < 31)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        start <= 1'b1;
        req <= r;
        // accepted at the first rising edge with busy low
        do @(posedge clk); while (busy);
    endtask

    // sender pauses until every outstanding request has its result
    task automatic drain_translations();
        @(negedge clk);
        start <= 1'b0;
        while (translations_pending != 0 || busy)
            @(negedge clk);
    endtask

    // config writes only while the block is idle
    task automatic write_active_entries(input logic [CFG_BITS-1:0] value);
        drain_translations();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [PAGE_BITS-1:0] page_pool [24];
        logic [PAGE_BITS-1:0] pg;
        logic [CFG_BITS-1:0]  phase_active;
        int                   pool_size;

        // every input known from time zero
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        gaps_on = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: all 16 entries active after reset
        issue_access(20'h00000, 1'b0, 20'h00000);   // miss, fills entry 0
        issue_access(20'hFFFFF, 1'b1, 20'hFFFFF);   // miss, fills entry 1
        issue_access(20'h00000, 1'b1, 20'h12345);   // hit, walk frame ignored
        issue_access(20'hFFFFF, 1'b0, 20'h00000);   // hit on a write-filled entry
        for (int i = 0; i < 14; i++)                // fill entries 2 to 15
            issue_access(20'h00010 + 20'(i), i[0], 20'h5A5A0 ^ 20'(i << 4));
        // table full and every entry used: sweep clears all, victim is entry 0
        issue_access(20'hABCDE, 1'b1, 20'hA5A5A);
        // page 0 was evicted; sweep skips used entry 0 and takes entry 1
        issue_access(20'h00000, 1'b0, 20'h0F0F0);

        // two active entries: page 0x15 lives in entry 7 but is out of reach,
        // so it is filled a second time lower down
        write_active_entries(CFG_BITS'(2));
        issue_access(20'h00015, 1'b1, 20'h77777);

        // setting above the depth acts as the full table: duplicate pages,
        // lowest entry wins
        write_active_entries(CFG_BITS'(31));
        issue_access(20'h00015, 1'b0, 20'h00001);

        // setting of zero acts as one entry
        write_active_entries(CFG_BITS'(0));
        issue_access(20'h12345, 1'b0, 20'h54321);
        issue_access(20'h12345, 1'b1, 20'h00000);

        // random phases: each picks an active count and a small page pool so
        // hits, fills and sweeps all happen often; a few pages are fully random
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: phase_active = CFG_BITS'(16);
                1: phase_active = CFG_BITS'(1);
                2: phase_active = CFG_BITS'(31);
                3: phase_active = CFG_BITS'(0);
                4: phase_active = CFG_BITS'(3);
                5: phase_active = CFG_BITS'(8);
                6: phase_active = CFG_BITS'(17);
                default: phase_active = CFG_BITS'($urandom_range(0, 31));
            endcase
            write_active_entries(phase_active);
            pool_size = $urandom_range(2, 24);
            for (int k = 0; k < pool_size; k++)
                page_pool[k] = PAGE_BITS'($urandom);
            // one long stretch with the sender never idling
            gaps_on = (ph != 2);
            for (int k = 0; k < PHASE_REQUESTS; k++)
            begin
                if ($urandom_range(0, 99) < 85)
                    pg = page_pool[$urandom_range(0, pool_size - 1)];
                else
                    pg = PAGE_BITS'($urandom);
                issue_access(pg, 1'($urandom_range(0, 1)), FRAME_BITS'($urandom));
            end
        end

        // wait out the last results plus one full request latency
        drain_translations();
        repeat (TLB_DEPTH_DEF + 2) @(posedge clk);
        if (mismatch_count == 0 && translations_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
